### hdl/rbar_pkg.sv
// ----------------------------------------------------------------------------
// Rigid body attitude rates: shared package
// Types, register indexes and rounding helpers used by the attitude rate
// pipeline and its two datapaths.
// ----------------------------------------------------------------------------
package rbar_pkg;

    // Pipeline depth, from input register to output register.
    localparam int NUM_STAGES = 6;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_INERTIA_XX = 3'd0,
        CFG_INERTIA_YY = 3'd1,
        CFG_INERTIA_ZZ = 3'd2,
        CFG_INERTIA_XY = 3'd3,
        CFG_INERTIA_XZ = 3'd4,
        CFG_INERTIA_YZ = 3'd5
    } t_cfg_reg;

    // Reset values of the inertia tensor, Q16.16.
    localparam logic signed [31:0] INERTIA_DIAG_RST = 32'sd65536;
    localparam logic signed [31:0] INERTIA_OFF_RST  = 32'sd0;

    // One in Q.32, the reference for the norm error.
    localparam logic signed [37:0] ONE_Q32 = 38'sh01_0000_0000;

    // Symmetric inertia tensor, six independent elements.
    typedef struct packed {
        logic signed [31:0] xx;
        logic signed [31:0] yy;
        logic signed [31:0] zz;
        logic signed [31:0] xy;
        logic signed [31:0] xz;
        logic signed [31:0] yz;
    } t_inertia;

    // Per-stage load enables, driven by the valid chain in the top level.
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } t_pipe_ctl;

    // Round a Q.48 value to Q.16 (nearest, ties up) and saturate to 32 bits.
    function automatic logic signed [31:0] rnd_sat_q48(input logic signed [61:0] a);
        logic signed [61:0] t;
        logic signed [61:0] s;
        t = a + (62'sd1 <<< 31);
        s = t >>> 32;
        if (s > 62'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (s < -62'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

    // Round a Q.32 value to Q.16 (nearest, ties up) and saturate to 32 bits.
    function automatic logic signed [31:0] rnd_sat_q32(input logic signed [57:0] a);
        logic signed [57:0] t;
        logic signed [57:0] s;
        t = a + (58'sd1 <<< 15);
        s = t >>> 16;
        if (s > 58'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (s < -58'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

endpackage

### hdl/rbar_quat_path.sv
// ----------------------------------------------------------------------------
// Rigid body attitude rates: quaternion derivative datapath
// Six-stage pipeline forming 0.5 * q (x) (0, r) + 50 * (1 - |q|^2) * q
// exactly in Q.48, then rounding and saturating to Q16.16.
// ----------------------------------------------------------------------------
module rbar_quat_path
    import rbar_pkg::*;
(
    input  logic               i_clk,
    input  t_pipe_ctl          i_ctl,
    input  logic signed [17:0] i_quat_w,
    input  logic signed [17:0] i_quat_x,
    input  logic signed [17:0] i_quat_y,
    input  logic signed [17:0] i_quat_z,
    input  logic signed [23:0] i_rate_x,
    input  logic signed [23:0] i_rate_y,
    input  logic signed [23:0] i_rate_z,
    output logic signed [31:0] o_dquat_w,
    output logic signed [31:0] o_dquat_x,
    output logic signed [31:0] o_dquat_y,
    output logic signed [31:0] o_dquat_z
);

    logic signed [17:0] q_in [4];
    logic signed [23:0] r_in [3];

    // Stage 1: rate by quaternion products and squares.
    logic signed [41:0] n_s1_rq [4][3];
    logic signed [41:0] r_s1_rq [4][3];
    logic signed [35:0] n_s1_sq [4];
    logic signed [35:0] r_s1_sq [4];
    logic signed [17:0] r_s1_q  [4];

    // Stage 2: product sums and norm error.
    logic signed [43:0] n_s2_p [4];
    logic signed [43:0] r_s2_p [4];
    logic signed [37:0] n_s2_err;
    logic signed [37:0] r_s2_err;
    logic signed [17:0] r_s2_q [4];

    // Stage 3: norm error times each component.
    logic signed [55:0] n_s3_eq [4];
    logic signed [55:0] r_s3_eq [4];
    logic signed [43:0] r_s3_p  [4];

    // Stage 4: gain of fifty by shift and add.
    logic signed [61:0] n_s4_m50 [4];
    logic signed [61:0] r_s4_m50 [4];
    logic signed [43:0] r_s4_p   [4];

    // Stage 5: full Q.48 accumulator.
    logic signed [61:0] n_s5_acc [4];
    logic signed [61:0] r_s5_acc [4];

    // Stage 6: rounded and saturated derivative.
    logic signed [31:0] n_s6_dq [4];
    logic signed [31:0] r_s6_dq [4];

    assign q_in[0] = i_quat_w;
    assign q_in[1] = i_quat_x;
    assign q_in[2] = i_quat_y;
    assign q_in[3] = i_quat_z;
    assign r_in[0] = i_rate_x;
    assign r_in[1] = i_rate_y;
    assign r_in[2] = i_rate_z;

    // The twelve products of the quaternion product, grouped by component.
    always_comb begin
        n_s1_rq[0][0] = 42'(r_in[0]) * 42'(q_in[1]);
        n_s1_rq[0][1] = 42'(r_in[1]) * 42'(q_in[2]);
        n_s1_rq[0][2] = 42'(r_in[2]) * 42'(q_in[3]);
        n_s1_rq[1][0] = 42'(r_in[0]) * 42'(q_in[0]);
        n_s1_rq[1][1] = 42'(r_in[2]) * 42'(q_in[2]);
        n_s1_rq[1][2] = 42'(r_in[1]) * 42'(q_in[3]);
        n_s1_rq[2][0] = 42'(r_in[1]) * 42'(q_in[0]);
        n_s1_rq[2][1] = 42'(r_in[2]) * 42'(q_in[1]);
        n_s1_rq[2][2] = 42'(r_in[0]) * 42'(q_in[3]);
        n_s1_rq[3][0] = 42'(r_in[2]) * 42'(q_in[0]);
        n_s1_rq[3][1] = 42'(r_in[1]) * 42'(q_in[1]);
        n_s1_rq[3][2] = 42'(r_in[0]) * 42'(q_in[2]);
        for (int k = 0; k < 4; k++) begin
            n_s1_sq[k] = 36'(q_in[k]) * 36'(q_in[k]);
        end
    end

    // Signed sums of the products and the deviation from unit norm.
    always_comb begin
        n_s2_p[0] = -44'(r_s1_rq[0][0]) - 44'(r_s1_rq[0][1]) - 44'(r_s1_rq[0][2]);
        n_s2_p[1] =  44'(r_s1_rq[1][0]) + 44'(r_s1_rq[1][1]) - 44'(r_s1_rq[1][2]);
        n_s2_p[2] =  44'(r_s1_rq[2][0]) - 44'(r_s1_rq[2][1]) + 44'(r_s1_rq[2][2]);
        n_s2_p[3] =  44'(r_s1_rq[3][0]) + 44'(r_s1_rq[3][1]) - 44'(r_s1_rq[3][2]);
        n_s2_err  = ONE_Q32 - (38'(r_s1_sq[0]) + 38'(r_s1_sq[1])
                             + 38'(r_s1_sq[2]) + 38'(r_s1_sq[3]));
    end

    // Renormalizing pull, then scaling and final sum per component.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_s3_eq[k]  = 56'(r_s2_err) * 56'(r_s2_q[k]);
            n_s4_m50[k] = (62'(r_s3_eq[k]) <<< 5) + (62'(r_s3_eq[k]) <<< 4)
                        + (62'(r_s3_eq[k]) <<< 1);
            n_s5_acc[k] = (62'(r_s4_p[k]) <<< 15) + r_s4_m50[k];
            n_s6_dq[k]  = rnd_sat_q48(r_s5_acc[k]);
        end
    end

    // Pipeline registers, each stage loads when its enable is set.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_s1_rq <= n_s1_rq;
            r_s1_sq <= n_s1_sq;
            r_s1_q  <= q_in;
        end
        if (i_ctl.en[1]) begin
            r_s2_p   <= n_s2_p;
            r_s2_err <= n_s2_err;
            r_s2_q   <= r_s1_q;
        end
        if (i_ctl.en[2]) begin
            r_s3_eq <= n_s3_eq;
            r_s3_p  <= r_s2_p;
        end
        if (i_ctl.en[3]) begin
            r_s4_m50 <= n_s4_m50;
            r_s4_p   <= r_s3_p;
        end
        if (i_ctl.en[4]) begin
            r_s5_acc <= n_s5_acc;
        end
        if (i_ctl.en[5]) begin
            r_s6_dq <= n_s6_dq;
        end
    end

    assign o_dquat_w = r_s6_dq[0];
    assign o_dquat_x = r_s6_dq[1];
    assign o_dquat_y = r_s6_dq[2];
    assign o_dquat_z = r_s6_dq[3];

endmodule

### hdl/rbar_torque_path.sv
// ----------------------------------------------------------------------------
// Rigid body attitude rates: net torque datapath
// Six-stage pipeline forming h = I r, the gyroscopic term r x h and the
// net torque T - r x h, rounded and saturated to Q16.16.
// ----------------------------------------------------------------------------
module rbar_torque_path
    import rbar_pkg::*;
(
    input  logic               i_clk,
    input  t_pipe_ctl          i_ctl,
    input  t_inertia           i_inertia,
    input  logic signed [23:0] i_rate_x,
    input  logic signed [23:0] i_rate_y,
    input  logic signed [23:0] i_rate_z,
    input  logic signed [31:0] i_applied_torque_x,
    input  logic signed [31:0] i_applied_torque_y,
    input  logic signed [31:0] i_applied_torque_z,
    output logic signed [31:0] o_net_torque_x,
    output logic signed [31:0] o_net_torque_y,
    output logic signed [31:0] o_net_torque_z
);

    logic signed [31:0] im   [3][3];
    logic signed [23:0] r_in [3];
    logic signed [31:0] t_in [3];

    // Stage 1: inertia by rate products.
    logic signed [55:0] n_s1_ir [3][3];
    logic signed [55:0] r_s1_ir [3][3];
    logic signed [23:0] r_s1_r  [3];
    logic signed [31:0] r_s1_t  [3];

    // Stage 2: unrounded angular momentum.
    logic signed [57:0] n_s2_hsum [3];
    logic signed [57:0] r_s2_hsum [3];
    logic signed [23:0] r_s2_r    [3];
    logic signed [31:0] r_s2_t    [3];

    // Stage 3: rounded and saturated angular momentum.
    logic signed [31:0] n_s3_h [3];
    logic signed [31:0] r_s3_h [3];
    logic signed [23:0] r_s3_r [3];
    logic signed [31:0] r_s3_t [3];

    // Stage 4: the two products of each cross product component.
    logic signed [55:0] n_s4_ca [3];
    logic signed [55:0] r_s4_ca [3];
    logic signed [55:0] n_s4_cb [3];
    logic signed [55:0] r_s4_cb [3];
    logic signed [31:0] r_s4_t  [3];

    // Stage 5: net torque in Q.32.
    logic signed [57:0] n_s5_net [3];
    logic signed [57:0] r_s5_net [3];

    // Stage 6: rounded and saturated net torque.
    logic signed [31:0] n_s6_out [3];
    logic signed [31:0] r_s6_out [3];

    // Full symmetric tensor from the six stored elements.
    always_comb begin
        im[0][0] = i_inertia.xx;
        im[0][1] = i_inertia.xy;
        im[0][2] = i_inertia.xz;
        im[1][0] = i_inertia.xy;
        im[1][1] = i_inertia.yy;
        im[1][2] = i_inertia.yz;
        im[2][0] = i_inertia.xz;
        im[2][1] = i_inertia.yz;
        im[2][2] = i_inertia.zz;
    end

    assign r_in[0] = i_rate_x;
    assign r_in[1] = i_rate_y;
    assign r_in[2] = i_rate_z;
    assign t_in[0] = i_applied_torque_x;
    assign t_in[1] = i_applied_torque_y;
    assign t_in[2] = i_applied_torque_z;

    // Per-axis arithmetic for every stage.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_s1_ir[i][j] = 56'(im[i][j]) * 56'(r_in[j]);
            end
            n_s2_hsum[i] = 58'(r_s1_ir[i][0]) + 58'(r_s1_ir[i][1]) + 58'(r_s1_ir[i][2]);
            n_s3_h[i]    = rnd_sat_q32(r_s2_hsum[i]);
            // Component i of r x h is r[i+1] h[i+2] - r[i+2] h[i+1], indexes mod 3.
            n_s4_ca[i]   = 56'(r_s3_r[(i + 1) % 3]) * 56'(r_s3_h[(i + 2) % 3]);
            n_s4_cb[i]   = 56'(r_s3_r[(i + 2) % 3]) * 56'(r_s3_h[(i + 1) % 3]);
            n_s5_net[i]  = (58'(r_s4_t[i]) <<< 16) - 58'(r_s4_ca[i]) + 58'(r_s4_cb[i]);
            n_s6_out[i]  = rnd_sat_q32(r_s5_net[i]);
        end
    end

    // Pipeline registers, each stage loads when its enable is set.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_s1_ir <= n_s1_ir;
            r_s1_r  <= r_in;
            r_s1_t  <= t_in;
        end
        if (i_ctl.en[1]) begin
            r_s2_hsum <= n_s2_hsum;
            r_s2_r    <= r_s1_r;
            r_s2_t    <= r_s1_t;
        end
        if (i_ctl.en[2]) begin
            r_s3_h <= n_s3_h;
            r_s3_r <= r_s2_r;
            r_s3_t <= r_s2_t;
        end
        if (i_ctl.en[3]) begin
            r_s4_ca <= n_s4_ca;
            r_s4_cb <= n_s4_cb;
            r_s4_t  <= r_s3_t;
        end
        if (i_ctl.en[4]) begin
            r_s5_net <= n_s5_net;
        end
        if (i_ctl.en[5]) begin
            r_s6_out <= n_s6_out;
        end
    end

    assign o_net_torque_x = r_s6_out[0];
    assign o_net_torque_y = r_s6_out[1];
    assign o_net_torque_z = r_s6_out[2];

endmodule

### hdl/rigid_body_attitude_rates.sv
// ----------------------------------------------------------------------------
// Rigid body attitude rates: top level
// Quaternion derivative with norm correction and net torque after the
// gyroscopic term, one body state per item.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while o_stall is low, and each
// item passes through the six register stages of the multiply and add
// pipeline (products, sums, rounding or scaling, cross products, final sums,
// output rounding). Each stage has its own valid bit and moves up whenever
// the stage after it is empty or moving, so empty slots close up under a
// stall and o_stall rises only when all six stages hold items. The inertia
// registers are written through a port that is always ready; they are to be
// changed only while no item is in flight.
module rigid_body_attitude_rates
    import rbar_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write channel.
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    // Input item channel.
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [17:0] i_quat_w,
    input  logic signed [17:0] i_quat_x,
    input  logic signed [17:0] i_quat_y,
    input  logic signed [17:0] i_quat_z,
    input  logic signed [23:0] i_rate_x,
    input  logic signed [23:0] i_rate_y,
    input  logic signed [23:0] i_rate_z,
    input  logic signed [31:0] i_applied_torque_x,
    input  logic signed [31:0] i_applied_torque_y,
    input  logic signed [31:0] i_applied_torque_z,
    // Result item channel.
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_dquat_w,
    output logic signed [31:0] o_dquat_x,
    output logic signed [31:0] o_dquat_y,
    output logic signed [31:0] o_dquat_z,
    output logic signed [31:0] o_net_torque_x,
    output logic signed [31:0] o_net_torque_y,
    output logic signed [31:0] o_net_torque_z
);

    t_inertia              r_inertia;
    t_inertia              n_inertia;
    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    t_pipe_ctl             ctl;

    // Configuration writes are taken in any cycle.
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_inertia = r_inertia;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INERTIA_XX: n_inertia.xx = i_cfg_data;
                CFG_INERTIA_YY: n_inertia.yy = i_cfg_data;
                CFG_INERTIA_ZZ: n_inertia.zz = i_cfg_data;
                CFG_INERTIA_XY: n_inertia.xy = i_cfg_data;
                CFG_INERTIA_XZ: n_inertia.xz = i_cfg_data;
                CFG_INERTIA_YZ: n_inertia.yz = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inertia.xx <= INERTIA_DIAG_RST;
            r_inertia.yy <= INERTIA_DIAG_RST;
            r_inertia.zz <= INERTIA_DIAG_RST;
            r_inertia.xy <= INERTIA_OFF_RST;
            r_inertia.xz <= INERTIA_OFF_RST;
            r_inertia.yz <= INERTIA_OFF_RST;
        end else begin
            r_inertia <= n_inertia;
        end
    end

    // Stage enables: a stage loads when it is empty or its contents move on.
    always_comb begin
        ctl.en[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            ctl.en[k] = !r_valid[k] || ctl.en[k+1];
        end
    end

    // Valid bits follow the data through the stages.
    always_comb begin
        n_valid = r_valid;
        if (ctl.en[0]) begin
            n_valid[0] = i_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (ctl.en[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_stall = !ctl.en[0];
    assign o_valid = r_valid[NUM_STAGES-1];

    // Quaternion derivative datapath.
    rbar_quat_path u_quat_path (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_quat_w  (i_quat_w),
        .i_quat_x  (i_quat_x),
        .i_quat_y  (i_quat_y),
        .i_quat_z  (i_quat_z),
        .i_rate_x  (i_rate_x),
        .i_rate_y  (i_rate_y),
        .i_rate_z  (i_rate_z),
        .o_dquat_w (o_dquat_w),
        .o_dquat_x (o_dquat_x),
        .o_dquat_y (o_dquat_y),
        .o_dquat_z (o_dquat_z)
    );

    // Net torque datapath.
    rbar_torque_path u_torque_path (
        .i_clk              (i_clk),
        .i_ctl              (ctl),
        .i_inertia          (r_inertia),
        .i_rate_x           (i_rate_x),
        .i_rate_y           (i_rate_y),
        .i_rate_z           (i_rate_z),
        .i_applied_torque_x (i_applied_torque_x),
        .i_applied_torque_y (i_applied_torque_y),
        .i_applied_torque_z (i_applied_torque_z),
        .o_net_torque_x     (o_net_torque_x),
        .o_net_torque_y     (o_net_torque_y),
        .o_net_torque_z     (o_net_torque_z)
    );

endmodule

### tb/rigid_body_attitude_rates_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rigid body attitude rates: result checker
// Watches the configuration, input and result channels of the block. It keeps
// its own copy of the inertia tensor and works out each expected result when
// an item is accepted. Each accepted result is compared field by field with
// the oldest expected result.
// ----------------------------------------------------------------------------
module rbar_rate_checker
    import rbar_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write channel.
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    // Input item channel.
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [17:0] i_quat_w,
    input  logic signed [17:0] i_quat_x,
    input  logic signed [17:0] i_quat_y,
    input  logic signed [17:0] i_quat_z,
    input  logic signed [23:0] i_rate_x,
    input  logic signed [23:0] i_rate_y,
    input  logic signed [23:0] i_rate_z,
    input  logic signed [31:0] i_applied_torque_x,
    input  logic signed [31:0] i_applied_torque_y,
    input  logic signed [31:0] i_applied_torque_z,
    // Result item channel.
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_dquat_w,
    input  logic signed [31:0] i_dquat_x,
    input  logic signed [31:0] i_dquat_y,
    input  logic signed [31:0] i_dquat_z,
    input  logic signed [31:0] i_net_torque_x,
    input  logic signed [31:0] i_net_torque_y,
    input  logic signed [31:0] i_net_torque_z,
    // Status for the testbench top.
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic signed [17:0] quat_w;
        logic signed [17:0] quat_x;
        logic signed [17:0] quat_y;
        logic signed [17:0] quat_z;
        logic signed [23:0] rate_x;
        logic signed [23:0] rate_y;
        logic signed [23:0] rate_z;
        logic signed [31:0] torque_x;
        logic signed [31:0] torque_y;
        logic signed [31:0] torque_z;
    } t_body;

    // Result fields: 0..3 are dquat w, x, y, z and 4..6 net torque x, y, z.
    typedef logic [6:0][31:0] t_rates;

    t_inertia inertia;
    t_rates   pending_rates [$];
    t_rates   expected;
    t_rates   actual;
    t_body    seen;
    int       fail_total = 0;

    function automatic string field_name(input int k);
        case (k)
            0: return "dquat_w";
            1: return "dquat_x";
            2: return "dquat_y";
            3: return "dquat_z";
            4: return "net_torque_x";
            5: return "net_torque_y";
            default: return "net_torque_z";
        endcase
    endfunction

    // Divide by 2^sh rounding to nearest with ties upward, then clamp to 32 bits.
    function automatic logic signed [31:0] round_sat(input longint v, input int unsigned sh);
        longint t;
        t = (v + (64'sd1 <<< (sh - 1))) >>> sh;
        if (t > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (t < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return 32'(t);
    endfunction

    // Quaternion derivative with norm pull, and applied minus gyroscopic torque.
    function automatic t_rates predict_rates(input t_body b, input t_inertia m);
        longint qw, qx, qy, qz, rx, ry, rz, tx, ty, tz;
        longint ixx, iyy, izz, ixy, ixz, iyz;
        longint q [4];
        longint p [4];
        longint norm_err, hx, hy, hz, cx, cy, cz;
        t_rates r;
        qw = b.quat_w;
        qx = b.quat_x;
        qy = b.quat_y;
        qz = b.quat_z;
        rx = b.rate_x;
        ry = b.rate_y;
        rz = b.rate_z;
        tx = b.torque_x;
        ty = b.torque_y;
        tz = b.torque_z;
        ixx = m.xx;
        iyy = m.yy;
        izz = m.zz;
        ixy = m.xy;
        ixz = m.xz;
        iyz = m.yz;
        q[0] = qw;
        q[1] = qx;
        q[2] = qy;
        q[3] = qz;

        // Product q (x) (0, r), Q.32.
        p[0] = -rx * qx - ry * qy - rz * qz;
        p[1] = rx * qw + rz * qy - ry * qz;
        p[2] = ry * qw - rz * qx + rx * qz;
        p[3] = rz * qw + ry * qx - rx * qy;

        // Deviation of the squared norm from one, Q.32.
        norm_err = (64'sd1 <<< 32) - (qw * qw + qx * qx + qy * qy + qz * qz);

        // Half the product plus the pull, both brought to Q.48.
        for (int k = 0; k < 4; k++) begin
            r[k] = round_sat(p[k] * 32768 + 50 * (norm_err * q[k]), 32);
        end

        // Angular momentum, clamped to Q16.16 before the cross product.
        hx = round_sat(ixx * rx + ixy * ry + ixz * rz, 16);
        hy = round_sat(ixy * rx + iyy * ry + iyz * rz, 16);
        hz = round_sat(ixz * rx + iyz * ry + izz * rz, 16);

        cx = ry * hz - rz * hy;
        cy = rz * hx - rx * hz;
        cz = rx * hy - ry * hx;

        r[4] = round_sat(tx * 65536 - cx, 16);
        r[5] = round_sat(ty * 65536 - cy, 16);
        r[6] = round_sat(tz * 65536 - cz, 16);
        return r;
    endfunction

    // Track register writes, predict on each accepted item, check each result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            inertia = '{xx: INERTIA_DIAG_RST, yy: INERTIA_DIAG_RST, zz: INERTIA_DIAG_RST,
                        xy: INERTIA_OFF_RST, xz: INERTIA_OFF_RST, yz: INERTIA_OFF_RST};
            pending_rates.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_INERTIA_XX: inertia.xx = i_cfg_data;
                    CFG_INERTIA_YY: inertia.yy = i_cfg_data;
                    CFG_INERTIA_ZZ: inertia.zz = i_cfg_data;
                    CFG_INERTIA_XY: inertia.xy = i_cfg_data;
                    CFG_INERTIA_XZ: inertia.xz = i_cfg_data;
                    CFG_INERTIA_YZ: inertia.yz = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                seen.quat_w   = i_quat_w;
                seen.quat_x   = i_quat_x;
                seen.quat_y   = i_quat_y;
                seen.quat_z   = i_quat_z;
                seen.rate_x   = i_rate_x;
                seen.rate_y   = i_rate_y;
                seen.rate_z   = i_rate_z;
                seen.torque_x = i_applied_torque_x;
                seen.torque_y = i_applied_torque_y;
                seen.torque_z = i_applied_torque_z;
                pending_rates.push_back(predict_rates(seen, inertia));
            end
            if (i_out_valid && !i_out_stall) begin
                actual = {i_net_torque_z, i_net_torque_y, i_net_torque_x,
                          i_dquat_z, i_dquat_y, i_dquat_x, i_dquat_w};
                if (pending_rates.size() == 0) begin
                    $error("result item with no prediction pending");
                    fail_total++;
                end else begin
                    expected = pending_rates.pop_front();
                    for (int k = 0; k < 7; k++) begin
                        if (actual[k] !== expected[k]) begin
                            $error("%s: expected %0d, actual %0d", field_name(k),
                                   $signed(expected[k]), $signed(actual[k]));
                            fail_total++;
                        end
                    end
                end
            end
        end
        o_pending    = pending_rates.size();
        o_fail_count = fail_total;
    end

endmodule

### tb/rigid_body_attitude_rates_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rigid body attitude rates: testbench top
// Drives a short directed set of body states, then random ones under several
// inertia settings and four idling patterns on both channels. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module rigid_body_attitude_rates_tb;
    import rbar_pkg::*;

    localparam int RUN_LIMIT_NS    = 1_000_000;
    localparam int NUM_SETTINGS    = 7;
    localparam int ITEMS_PER_PHASE = 30;
    localparam int ONE_Q16         = 65536;

    // Indexes past the last inertia register; the block ignores them.
    localparam logic [2:0] CFG_SPARE_LO = 3'(CFG_INERTIA_YZ) + 3'd1;
    localparam logic [2:0] CFG_SPARE_HI = 3'(CFG_INERTIA_YZ) + 3'd2;

    localparam logic signed [17:0] Q_MAX = 18'sh1FFFF;
    localparam logic signed [17:0] Q_MIN = 18'sh20000;
    localparam logic signed [23:0] R_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] R_MIN = 24'sh800000;
    localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] T_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [17:0] quat_w;
        logic signed [17:0] quat_x;
        logic signed [17:0] quat_y;
        logic signed [17:0] quat_z;
        logic signed [23:0] rate_x;
        logic signed [23:0] rate_y;
        logic signed [23:0] rate_z;
        logic signed [31:0] torque_x;
        logic signed [31:0] torque_y;
        logic signed [31:0] torque_z;
    } t_body;

    logic               i_clk;
    logic               i_rst_n            = 1'b0;
    logic               i_cfg_valid        = 1'b0;
    logic [2:0]         i_cfg_index        = '0;
    logic [31:0]        i_cfg_data         = '0;
    logic               i_valid            = 1'b0;
    logic signed [17:0] i_quat_w           = '0;
    logic signed [17:0] i_quat_x           = '0;
    logic signed [17:0] i_quat_y           = '0;
    logic signed [17:0] i_quat_z           = '0;
    logic signed [23:0] i_rate_x           = '0;
    logic signed [23:0] i_rate_y           = '0;
    logic signed [23:0] i_rate_z           = '0;
    logic signed [31:0] i_applied_torque_x = '0;
    logic signed [31:0] i_applied_torque_y = '0;
    logic signed [31:0] i_applied_torque_z = '0;
    logic               i_stall            = 1'b0;
    logic               o_cfg_ready;
    logic               o_stall;
    logic               o_valid;
    logic signed [31:0] o_dquat_w;
    logic signed [31:0] o_dquat_x;
    logic signed [31:0] o_dquat_y;
    logic signed [31:0] o_dquat_z;
    logic signed [31:0] o_net_torque_x;
    logic signed [31:0] o_net_torque_y;
    logic signed [31:0] o_net_torque_z;
    int                 fail_count;
    int                 results_pending;

    // Chances in a hundred of a sender gap and of a receiver stall per cycle.
    int unsigned        idle_pct  = 0;
    int unsigned        stall_pct = 0;

    rigid_body_attitude_rates i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_quat_w           (i_quat_w),
        .i_quat_x           (i_quat_x),
        .i_quat_y           (i_quat_y),
        .i_quat_z           (i_quat_z),
        .i_rate_x           (i_rate_x),
        .i_rate_y           (i_rate_y),
        .i_rate_z           (i_rate_z),
        .i_applied_torque_x (i_applied_torque_x),
        .i_applied_torque_y (i_applied_torque_y),
        .i_applied_torque_z (i_applied_torque_z),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_dquat_w          (o_dquat_w),
        .o_dquat_x          (o_dquat_x),
        .o_dquat_y          (o_dquat_y),
        .o_dquat_z          (o_dquat_z),
        .o_net_torque_x     (o_net_torque_x),
        .o_net_torque_y     (o_net_torque_y),
        .o_net_torque_z     (o_net_torque_z)
    );

    rbar_rate_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_valid),
        .i_in_stall         (o_stall),
        .i_quat_w           (i_quat_w),
        .i_quat_x           (i_quat_x),
        .i_quat_y           (i_quat_y),
        .i_quat_z           (i_quat_z),
        .i_rate_x           (i_rate_x),
        .i_rate_y           (i_rate_y),
        .i_rate_z           (i_rate_z),
        .i_applied_torque_x (i_applied_torque_x),
        .i_applied_torque_y (i_applied_torque_y),
        .i_applied_torque_z (i_applied_torque_z),
        .i_out_valid        (o_valid),
        .i_out_stall        (i_stall),
        .i_dquat_w          (o_dquat_w),
        .i_dquat_x          (o_dquat_x),
        .i_dquat_y          (o_dquat_y),
        .i_dquat_z          (o_dquat_z),
        .i_net_torque_x     (o_net_torque_x),
        .i_net_torque_y     (o_net_torque_y),
        .i_net_torque_z     (o_net_torque_z),
        .o_fail_count       (fail_count),
        .o_pending          (results_pending)
    );

    // 4 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Hard stop in case the block hangs.
    initial begin
        #(RUN_LIMIT_NS * 1ns);
        $display("** rigid_body_attitude_rates: FAILED **");
        $finish;
    end

    // One of the two extremes of a w-bit signed field, zero, or minus one.
    function automatic longint extreme_of(input int unsigned w);
        case ($urandom_range(3))
            0: return (64'sd1 <<< (w - 1)) - 1;
            1: return -(64'sd1 <<< (w - 1));
            2: return 0;
            default: return -1;
        endcase
    endfunction

    // Uniform value in [-m, m].
    function automatic int around_zero(input int m);
        return int'($urandom_range(2 * m)) - m;
    endfunction

    function automatic t_body make_body(
        input logic signed [17:0] qw, input logic signed [17:0] qx,
        input logic signed [17:0] qy, input logic signed [17:0] qz,
        input logic signed [23:0] rx, input logic signed [23:0] ry,
        input logic signed [23:0] rz,
        input logic signed [31:0] tx, input logic signed [31:0] ty,
        input logic signed [31:0] tz
    );
        t_body b;
        b = '{quat_w: qw, quat_x: qx, quat_y: qy, quat_z: qz,
              rate_x: rx, rate_y: ry, rate_z: rz,
              torque_x: tx, torque_y: ty, torque_z: tz};
        return b;
    endfunction

    // Mostly near-unit attitudes and moderate rates, with full-range and
    // extreme fields mixed in.
    function automatic t_body random_body();
        t_body       b;
        int unsigned pick;
        int          vx, vy, vz, vw;
        real         rest;
        pick = $urandom_range(9);
        if (pick < 6) begin
            vx = around_zero(32768);
            vy = around_zero(32768);
            vz = around_zero(32768);
            rest = 4294967296.0 - real'(vx * vx) - real'(vy * vy) - real'(vz * vz);
            vw = int'($sqrt(rest));
            if ($urandom_range(1) == 1) begin
                vw = -vw;
            end
            b.quat_w = 18'(vw + around_zero(16));
            b.quat_x = 18'(vx + around_zero(16));
            b.quat_y = 18'(vy + around_zero(16));
            b.quat_z = 18'(vz + around_zero(16));
        end else if (pick < 8) begin
            b.quat_w = 18'($urandom);
            b.quat_x = 18'($urandom);
            b.quat_y = 18'($urandom);
            b.quat_z = 18'($urandom);
        end else if (pick == 8) begin
            b.quat_w = 18'(around_zero(256));
            b.quat_x = 18'(around_zero(256));
            b.quat_y = 18'(around_zero(256));
            b.quat_z = 18'(around_zero(256));
        end else begin
            b.quat_w = 18'(extreme_of(18));
            b.quat_x = 18'(extreme_of(18));
            b.quat_y = 18'(extreme_of(18));
            b.quat_z = 18'(extreme_of(18));
        end

        pick = $urandom_range(9);
        if (pick < 7) begin
            b.rate_x = 24'(around_zero(1 << 18));
            b.rate_y = 24'(around_zero(1 << 18));
            b.rate_z = 24'(around_zero(1 << 18));
        end else if (pick < 9) begin
            b.rate_x = 24'($urandom);
            b.rate_y = 24'($urandom);
            b.rate_z = 24'($urandom);
        end else begin
            b.rate_x = 24'(extreme_of(24));
            b.rate_y = 24'(extreme_of(24));
            b.rate_z = 24'(extreme_of(24));
        end

        pick = $urandom_range(9);
        if (pick < 6) begin
            b.torque_x = 32'(around_zero(1 << 22));
            b.torque_y = 32'(around_zero(1 << 22));
            b.torque_z = 32'(around_zero(1 << 22));
        end else if (pick < 9) begin
            b.torque_x = $urandom;
            b.torque_y = $urandom;
            b.torque_z = $urandom;
        end else begin
            b.torque_x = 32'(extreme_of(32));
            b.torque_y = 32'(extreme_of(32));
            b.torque_z = 32'(extreme_of(32));
        end
        return b;
    endfunction

    // Offer one item, holding it steady until the block takes it.
    task automatic send_body(input t_body b);
        bit offered;
        bit taken;
        offered = 1'b0;
        taken   = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            if (!offered) begin
                if ($urandom_range(99) < idle_pct) begin
                    i_valid <= 1'b0;
                end else begin
                    i_valid            <= 1'b1;
                    i_quat_w           <= b.quat_w;
                    i_quat_x           <= b.quat_x;
                    i_quat_y           <= b.quat_y;
                    i_quat_z           <= b.quat_z;
                    i_rate_x           <= b.rate_x;
                    i_rate_y           <= b.rate_y;
                    i_rate_z           <= b.rate_z;
                    i_applied_torque_x <= b.torque_x;
                    i_applied_torque_y <= b.torque_y;
                    i_applied_torque_z <= b.torque_z;
                    offered = 1'b1;
                end
            end
            @(posedge i_clk);
            taken = offered && !o_stall;
        end
    endtask

    // Stop sending and wait until every predicted result has been taken.
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (results_pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic cfg_write(input logic [2:0] index, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Load the whole tensor, plus one write to an unused index.
    task automatic set_inertia(
        input logic [31:0] xx, input logic [31:0] yy, input logic [31:0] zz,
        input logic [31:0] xy, input logic [31:0] xz, input logic [31:0] yz
    );
        cfg_write(CFG_INERTIA_XX, xx);
        cfg_write(CFG_INERTIA_YY, yy);
        cfg_write(CFG_INERTIA_ZZ, zz);
        cfg_write(CFG_INERTIA_XY, xy);
        cfg_write(CFG_INERTIA_XZ, xz);
        cfg_write(CFG_INERTIA_YZ, yz);
        cfg_write(($urandom_range(1) == 1) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
    endtask

    // Stimulus.
    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under the reset tensor, no idling.
        send_body(make_body('0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_body(make_body(18'(ONE_Q16), '0, '0, '0, 24'(ONE_Q16), '0, '0, '0, '0, '0));
        send_body(make_body(Q_MAX, Q_MAX, Q_MAX, Q_MAX, R_MAX, R_MAX, R_MAX,
                            T_MAX, T_MAX, T_MAX));
        send_body(make_body(Q_MIN, Q_MIN, Q_MIN, Q_MIN, R_MIN, R_MIN, R_MIN,
                            T_MIN, T_MIN, T_MIN));
        send_body(make_body(Q_MIN, Q_MAX, Q_MIN, Q_MAX, R_MAX, R_MIN, R_MAX,
                            T_MIN, T_MAX, '0));
        send_body(make_body(18'sd46341, 18'sd46341, '0, '0, 24'sd65536, 24'sd131072,
                            -24'sd196608, 32'sd65536, -32'sd65536, 32'sd1));
        send_body(make_body('0, '0, '0, '0, '0, '0, '0, -32'sd1, 32'sd1, T_MAX));
        send_body(make_body(18'sd1, 18'sd1, -18'sd1, 18'sd1, 24'sd1, -24'sd1, 24'sd1,
                            -32'sd1, '0, 32'sd1));

        // Extreme tensor: momentum and net torque saturate.
        drain_results();
        set_inertia(T_MAX, T_MIN, T_MAX, T_MIN, T_MAX, T_MIN);
        send_body(make_body(18'(ONE_Q16), '0, '0, '0, R_MAX, R_MIN, R_MAX, '0, '0, '0));
        send_body(make_body(18'(ONE_Q16), '0, '0, '0, R_MIN, R_MAX, R_MAX,
                            T_MAX, T_MIN, T_MAX));
        send_body(make_body('0, '0, '0, '0, R_MAX, R_MAX, R_MAX, T_MIN, T_MIN, T_MIN));
        send_body(make_body('0, '0, '0, '0, '0, '0, '0, T_MAX, T_MIN, '0));
        send_body(make_body('0, '0, '0, '0, 24'sd65536, -24'sd65536, 24'sd1,
                            '0, '0, '0));
        drain_results();

        // Random items: each tensor setting runs all four idling patterns.
        for (int s = 0; s < NUM_SETTINGS; s++) begin
            idle_pct  = 0;
            stall_pct = 0;
            case (s)
                0: set_inertia(ONE_Q16, ONE_Q16, ONE_Q16, '0, '0, '0);
                1: set_inertia('0, '0, '0, '0, '0, '0);
                2: set_inertia(32'(extreme_of(32)), 32'(extreme_of(32)), 32'(extreme_of(32)),
                               32'(extreme_of(32)), 32'(extreme_of(32)),
                               32'(extreme_of(32)));
                3: set_inertia($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                default: set_inertia($urandom_range(1 << 22, 1 << 12),
                                     $urandom_range(1 << 22, 1 << 12),
                                     $urandom_range(1 << 22, 1 << 12),
                                     32'(around_zero(1 << 18)),
                                     32'(around_zero(1 << 18)),
                                     32'(around_zero(1 << 18)));
            endcase
            for (int ph = 0; ph < 4; ph++) begin
                case (ph)
                    0: begin idle_pct = 0;  stall_pct = 0;  end
                    1: begin idle_pct = 68; stall_pct = 0;  end
                    2: begin idle_pct = 0;  stall_pct = 68; end
                    default: begin idle_pct = 35; stall_pct = 35; end
                endcase
                for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                    send_body(random_body());
                    // Now and then the sender holds off until the pipe is empty.
                    if ($urandom_range(49) == 0) begin
                        drain_results();
                    end
                end
            end
            drain_results();
        end

        // Let any stray result show up before the verdict.
        stall_pct = 0;
        repeat (4 * NUM_STAGES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** rigid_body_attitude_rates: PASSED **");
        end else begin
            $display("** rigid_body_attitude_rates: FAILED **");
        end
        $finish;
    end

endmodule
